// ----- src/packed_variable_store_top_macros.svh -----
// Assertion macros used by the top level of the packed variable store.
`ifndef PACKED_VARIABLE_STORE_TOP_MACROS_SVH
`define PACKED_VARIABLE_STORE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define PVS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packed variable store assertion failed");
`define PVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packed variable store assertion failed");
`else
`define PVS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/pvs_pkg.sv -----
// Shared types, constants and helper functions of the packed variable store.
package pvs_pkg;

    localparam int KIND_COUNT         = 8;
    localparam int KIND_W             = 3;
    localparam int WIDTH_W            = 6;
    localparam int SHIFT_W            = 5;
    localparam int WORD_W             = 7;
    localparam int RT_WORD_W          = 10;
    localparam int BASE_W             = 9;
    localparam int DATA_W             = 32;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [KIND_W-1:0]  FIRST_RUNTIME_KIND = 3'd3;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET        = 6'd32;

    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_NARROW = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic                   runtime;
        logic                   out_of_range;
        logic [SHIFT_W-1:0]     shift;
        logic [WIDTH_W-1:0]     width;
        logic [WORD_W-1:0]      game_word;
        logic [RT_WORD_W-1:0]   rt_word;
        logic [DATA_W-1:0]      write_value;
    } pvs_entry_t;

    function automatic logic [DATA_W-1:0] field_mask(input logic [WIDTH_W-1:0] bits);
        logic [DATA_W-1:0] m;
        if (bits >= 6'd32)
        begin
            m = '1;
        end
        else
        begin
            m = (32'h1 << bits[SHIFT_W-1:0]) - 32'h1;
        end
        return m;
    endfunction

endpackage

// ----- src/pvs_front.sv -----
// Front end: width registers, reference decoding and range classification.
module pvs_front
    import pvs_pkg::*;
#(
    parameter int GAME_WORDS    = 128,
    parameter int RUNTIME_WORDS = 512
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [KIND_W-1:0]    cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [15:0]          var_ref,
    input  logic [BASE_W-1:0]    owner_base,
    input  logic [DATA_W-1:0]    write_value,
    input  logic                 clear_busy,
    input  logic                 q_full,
    output logic                 push,
    output pvs_entry_t           entry
);

    localparam logic [WORD_W:0]    GAME_LIMIT = (WORD_W+1)'(GAME_WORDS);
    localparam logic [12:0]        RT_LIMIT   = 13'(RUNTIME_WORDS);

    logic [WIDTH_W-1:0] width_reg [KIND_COUNT];

    logic [KIND_W-1:0]    kind;
    logic [WIDTH_W-1:0]   width;
    logic [WORD_W-1:0]    word;
    logic [RT_WORD_W-1:0] rt_word;
    logic                 runtime;
    logic                 range_err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KIND_COUNT; k++)
            begin
                width_reg[k] <= WIDTH_RESET;
            end
        end
        else if (cfg_we)
        begin
            width_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        kind    = var_ref[14:12];
        word    = var_ref[11:5];
        width   = width_reg[kind];
        runtime = (kind >= FIRST_RUNTIME_KIND);
        rt_word = RT_WORD_W'(word) + (var_ref[15] ? RT_WORD_W'(owner_base) : '0);
        if (runtime)
        begin
            range_err = (13'(rt_word) >= RT_LIMIT);
        end
        else
        begin
            range_err = ((WORD_W+1)'(word) >= GAME_LIMIT);
        end

        entry.runtime      = runtime;
        entry.out_of_range = range_err;
        entry.shift        = var_ref[4:0];
        entry.game_word    = word;
        entry.rt_word      = rt_word;
        entry.write_value  = write_value;
        entry.width        = width;
        entry.op           = OP_NONE;
        if (!range_err)
        begin
            case (mode)
                MODE_READ:   entry.op = OP_READ;
                MODE_WRITE:  entry.op = OP_WRITE;
                MODE_NARROW:
                begin
                    if (width != '0)
                    begin
                        entry.op    = OP_WRITE;
                        entry.width = width - 6'd1;
                    end
                end
                default:     entry.op = OP_NONE;
            endcase
        end
    end

    assign in_stall = clear_busy || q_full;
    assign push     = in_valid && !in_stall;

endmodule

// ----- src/pvs_queue.sv -----
// Small FIFO of decoded transactions between the front and back ends.
module pvs_queue
    import pvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pvs_entry_t  push_entry,
    input  logic        pop,
    output pvs_entry_t  head,
    output logic        empty,
    output logic        full
);

    // The depth is a power of two, so the pointers wrap on their own.
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    pvs_entry_t       entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head  = entries_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));

endmodule

// ----- src/pvs_back.sv -----
// Back end: both word banks, the read-modify-write sequencer and the result register.
module pvs_back
    import pvs_pkg::*;
#(
    parameter int GAME_WORDS    = 128,
    parameter int RUNTIME_WORDS = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  pvs_entry_t         q_head,
    output logic               pop,
    output logic               clear_busy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DATA_W-1:0]  read_value,
    output logic               out_of_range
);

    localparam int GAW = (GAME_WORDS > 1) ? $clog2(GAME_WORDS) : 1;
    localparam int RAW = $clog2(RUNTIME_WORDS);
    localparam logic [RAW:0]   GAME_CLEAR_LIMIT = (RAW+1)'(GAME_WORDS);
    localparam logic [RAW-1:0] CLEAR_LAST       = RAW'(RUNTIME_WORDS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    state_t             state_reg;
    logic [RAW-1:0]     clr_cnt_reg;
    pvs_entry_t         cur_reg;
    logic               out_valid_reg;
    logic [DATA_W-1:0]  read_value_reg;
    logic               out_of_range_reg;

    logic [DATA_W-1:0]  game_mem [GAME_WORDS];
    logic [DATA_W-1:0]  rt_mem   [RUNTIME_WORDS];
    logic [DATA_W-1:0]  game_rdata_reg;
    logic [DATA_W-1:0]  rt_rdata_reg;

    logic               slot_free;
    logic               exec_fire;
    logic [DATA_W-1:0]  rdata;
    logic [DATA_W-1:0]  fmask;
    logic [DATA_W-1:0]  wmask;
    logic [DATA_W-1:0]  new_word;
    logic [DATA_W-1:0]  result;
    logic               game_we;
    logic               rt_we;
    logic [GAW-1:0]     game_waddr;
    logic [RAW-1:0]     rt_waddr;
    logic [DATA_W-1:0]  wdata;
    logic [GAW-1:0]     game_raddr;
    logic [RAW-1:0]     rt_raddr;

    always_comb
    begin
        slot_free  = !out_valid_reg || !out_stall;
        exec_fire  = (state_reg == ST_EXEC) && slot_free;
        pop        = (state_reg == ST_IDLE) && !q_empty;
        clear_busy = (state_reg == ST_CLEAR);

        rdata    = cur_reg.runtime ? rt_rdata_reg : game_rdata_reg;
        fmask    = field_mask(cur_reg.width);
        wmask    = fmask << cur_reg.shift;
        new_word = (rdata & ~wmask) | ((cur_reg.write_value << cur_reg.shift) & wmask);
        result   = (cur_reg.op == OP_READ) ? ((rdata >> cur_reg.shift) & fmask) : '0;

        game_raddr = cur_reg.game_word[GAW-1:0];
        rt_raddr   = RAW'(cur_reg.rt_word);

        if (clear_busy)
        begin
            game_we    = ({1'b0, clr_cnt_reg} < GAME_CLEAR_LIMIT);
            rt_we      = 1'b1;
            game_waddr = clr_cnt_reg[GAW-1:0];
            rt_waddr   = clr_cnt_reg;
            wdata      = '0;
        end
        else
        begin
            game_we    = exec_fire && (cur_reg.op == OP_WRITE) && !cur_reg.runtime;
            rt_we      = exec_fire && (cur_reg.op == OP_WRITE) && cur_reg.runtime;
            game_waddr = game_raddr;
            rt_waddr   = rt_raddr;
            wdata      = new_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (game_we)
        begin
            game_mem[game_waddr] <= wdata;
        end
        game_rdata_reg <= game_mem[game_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rt_we)
        begin
            rt_mem[rt_waddr] <= wdata;
        end
        rt_rdata_reg <= rt_mem[rt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            cur_reg          <= '0;
            out_valid_reg    <= 1'b0;
            read_value_reg   <= '0;
            out_of_range_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !exec_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLEAR_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        cur_reg   <= q_head;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (exec_fire)
                    begin
                        out_valid_reg    <= 1'b1;
                        read_value_reg   <= result;
                        out_of_range_reg <= cur_reg.out_of_range;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign out_of_range = out_of_range_reg;

endmodule

// ----- src/packed_variable_store_top.sv -----
// Top level of the packed variable store: front end, transaction queue and back end.
// A transaction accepted into the queue goes through the back end's idle, read and
// execute states before out_valid shows its result; out_stall can hold it in execute.
// The back end takes no new transaction until the last one's read, modify and write
// sequence through the one read and one write port of each word bank is done.
// Reset: width registers return to 32; in_stall stays high while both banks are zeroed.
`include "packed_variable_store_top_macros.svh"
module packed_variable_store_top
    import pvs_pkg::*;
#(
    parameter int GAME_WORDS    = 128,
    parameter int RUNTIME_WORDS = 512
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [KIND_W-1:0]    cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [15:0]          var_ref,
    input  logic [BASE_W-1:0]    owner_base,
    input  logic [DATA_W-1:0]    write_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DATA_W-1:0]    read_value,
    output logic                 out_of_range
);

    // The front end decodes each incoming transaction in the cycle it arrives: it picks
    // the kind's width and bank, resolves the word index (adding the local base for
    // relative runtime references), checks it against the bank depth, and reduces the
    // access to a single operation (none, read or write) with its effective field width.
    // Decoded transactions wait in a short queue, so the input side keeps moving while
    // the back end works on an earlier transaction or waits on a stalled output.

    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    logic       clear_busy;
    pvs_entry_t push_entry;
    pvs_entry_t q_head;

    pvs_front #(
        .GAME_WORDS    (GAME_WORDS),
        .RUNTIME_WORDS (RUNTIME_WORDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .var_ref     (var_ref),
        .owner_base  (owner_base),
        .write_value (write_value),
        .clear_busy  (clear_busy),
        .q_full      (q_full),
        .push        (push),
        .entry       (push_entry)
    );

    pvs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // The back end takes one transaction at a time: it reads the addressed word into a
    // registered read port, then extracts the field or merges the new field bits and
    // writes the word back while loading the result register. The result register lets
    // the back end finish a transaction only when the previous result has been taken
    // or is being taken in the same cycle.

    pvs_back #(
        .GAME_WORDS    (GAME_WORDS),
        .RUNTIME_WORDS (RUNTIME_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (pop),
        .clear_busy   (clear_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .out_of_range (out_of_range)
    );

    // No transaction may enter while the banks are still being cleared.
    `PVS_ASSERT_IMPLIES(a_no_accept_in_clear, clk, rst_n, clear_busy, in_stall)
    // The queue never takes a transaction while it is full.
    `PVS_ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, q_full, !push)
    // No result can appear during the clearing pass.
    `PVS_ASSERT_IMPLIES(a_no_result_in_clear, clk, rst_n, clear_busy, !out_valid)
    // A transaction leaves the queue only when one is stored there.
    `PVS_ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst_n, pop, !q_empty)

endmodule

// ----- test/packed_variable_store_top_tb.sv -----
// Self-checking testbench for the packed variable store: directed and random accesses.
module packed_variable_store_top_tb
    import pvs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Bank sizes handed to the block; the predictor uses the same values.
    localparam int GAME_WORDS    = 128;
    localparam int RUNTIME_WORDS = 512;

    // Mode 3 performs no access but still reports the range check.
    localparam logic [1:0] MODE_IDLE = 2'd3;

    // Quiet cycles waited after the last result, so the block is fully idle before a width
    // register is touched.
    localparam int SETTLE_CYCLES = 8;

    // The slowest legal run is roughly 1800 transactions, each behind the longest sender
    // gap and the longest receiver stall, plus the clearing pass. The limit is several
    // times that.
    localparam int CYCLE_LIMIT = 1000000;

    // Mismatch lines beyond this count are counted but not printed.
    localparam int PRINT_CAP = 200;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              oor;
    } access_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [KIND_W-1:0]   cfg_index = '0;
    logic [WIDTH_W-1:0]  cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          mode = MODE_READ;
    logic [15:0]         var_ref = '0;
    logic [BASE_W-1:0]   owner_base = '0;
    logic [DATA_W-1:0]   write_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DATA_W-1:0]   read_value;
    logic                out_of_range;

    // Predictor state: both banks and the width of every kind, as the block holds them.
    logic [DATA_W-1:0]   game_bank [GAME_WORDS];
    logic [DATA_W-1:0]   runtime_bank [RUNTIME_WORDS];
    logic [WIDTH_W-1:0]  kind_widths [KIND_COUNT];

    // Results predicted for accepted transactions, oldest first.
    access_result_t      pending_results [$];

    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  send_quiet = 0;
    int                  stall_run = 0;
    logic                stall_level = 1'b0;

    packed_variable_store_top #(
        .GAME_WORDS    (GAME_WORDS),
        .RUNTIME_WORDS (RUNTIME_WORDS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .var_ref      (var_ref),
        .owner_base   (owner_base),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .out_of_range (out_of_range)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Mask of the low bits of a field; any width of 32 or more selects the whole word,
    // which falls out of doing the shift in 64 bits.
    function automatic logic [DATA_W-1:0] low_ones(input logic [WIDTH_W-1:0] bits);
        logic [63:0] wide;
        wide = (64'd1 << bits) - 64'd1;
        return wide[DATA_W-1:0];
    endfunction

    // Resolves the reference, applies the access to the predictor's banks and returns
    // the result the block must produce for it.
    function automatic access_result_t predict_access(input logic [1:0] op_mode,
                                                      input logic [15:0] vref,
                                                      input logic [BASE_W-1:0] base,
                                                      input logic [DATA_W-1:0] wdata);
        access_result_t    res;
        logic [SHIFT_W-1:0] shift;
        logic [KIND_W-1:0] kind;
        logic [WIDTH_W-1:0] width;
        logic              runtime;
        int unsigned       word;
        logic [DATA_W-1:0] cur;
        logic [DATA_W-1:0] field;
        shift   = vref[4:0];
        word    = vref[11:5];
        kind    = vref[14:12];
        width   = kind_widths[kind];
        runtime = (kind >= FIRST_RUNTIME_KIND);
        // The relative bit only means something for the runtime bank.
        if (runtime && vref[15])
        begin
            word += base;
        end
        res.value = '0;
        res.oor   = runtime ? (word >= RUNTIME_WORDS) : (word >= GAME_WORDS);
        if (!res.oor)
        begin
            cur = runtime ? runtime_bank[word] : game_bank[word];
            if (op_mode == MODE_READ)
            begin
                res.value = (cur >> shift) & low_ones(width);
            end
            else if (op_mode == MODE_WRITE || (op_mode == MODE_NARROW && width != '0))
            begin
                // Bits pushed above bit 31 by the shift are simply lost.
                field = low_ones(op_mode == MODE_NARROW ? width - 6'd1 : width) << shift;
                cur   = (cur & ~field) | ((wdata << shift) & field);
                if (runtime)
                begin
                    runtime_bank[word] = cur;
                end
                else
                begin
                    game_bank[word] = cur;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        if (error_count < PRINT_CAP)
        begin
            $display("%0t ns: mismatch on %s: expected %h, got %h", $realtime, what,
                     want, got);
        end
        error_count++;
    endtask

    // Every transaction on the result channel is matched against the oldest prediction.
    // Outputs are sampled at the rising edge, before the block's own updates land.
    always @(posedge clk)
    begin : check_results
        access_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", '0, read_value);
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.value)
                begin
                    report_mismatch("read_value", want.value, read_value);
                end
                if (out_of_range !== want.oor)
                begin
                    report_mismatch("out_of_range", DATA_W'(want.oor),
                                    DATA_W'(out_of_range));
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("packed_variable_store_top_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure
    // ------------------------------------------------------------------

    // The stall level is held for a run of cycles. Most runs are short, a few are long,
    // and now and then a long stretch with no stall at all lets the block stream.
    always @(negedge clk)
    begin : drive_out_stall
        int pick;
        if (stall_run > 0)
        begin
            stall_run--;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                stall_level = 1'b0;
                stall_run   = $urandom_range(20, 80);
            end
            else if (pick < 55)
            begin
                stall_level = 1'b0;
                stall_run   = $urandom_range(0, 3);
            end
            else if (pick < 90)
            begin
                stall_level = 1'b1;
                stall_run   = $urandom_range(0, 2);
            end
            else if (pick < 98)
            begin
                stall_level = 1'b1;
                stall_run   = $urandom_range(3, 12);
            end
            else
            begin
                stall_level = 1'b1;
                stall_run   = $urandom_range(20, 60);
            end
        end
        out_stall <= stall_level;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Idle cycles before the next transaction, with occasional stretches of none.
    function automatic int pick_gap();
        int pick;
        if (send_quiet > 0)
        begin
            send_quiet--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            send_quiet = $urandom_range(20, 80);
            return 0;
        end
        if (pick < 55)
        begin
            return 0;
        end
        if (pick < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] make_ref(input logic rel, input logic [KIND_W-1:0] kind,
                                             input logic [WORD_W-1:0] word,
                                             input logic [SHIFT_W-1:0] shift);
        return {rel, kind, word, shift};
    endfunction

    // Presents one transaction from a falling edge, holds it until the block takes it,
    // and records the predicted result at the accepting edge. The valid stays high on
    // return so that back-to-back transactions need no dead cycle.
    task automatic send_access(input logic [1:0] op_mode, input logic [15:0] vref,
                               input logic [BASE_W-1:0] base,
                               input logic [DATA_W-1:0] wdata);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op_mode;
        var_ref     <= vref;
        owner_base  <= base;
        write_value <= wdata;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_results.push_back(predict_access(op_mode, vref, base, wdata));
    endtask

    // Drops the valid and waits until every predicted result has been checked, then
    // lets the pipeline settle so the block is idle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all eight width registers on consecutive cycles; kind k sits at bits
    // [6k+5:6k]. Only called with the block drained.
    task automatic configure_widths(input logic [KIND_COUNT*WIDTH_W-1:0] widths);
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= k[KIND_W-1:0];
            cfg_data  <= widths[k*WIDTH_W +: WIDTH_W];
            kind_widths[k] = widths[k*WIDTH_W +: WIDTH_W];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random access. Most traffic goes to a handful of hot words at both ends of
    // the banks so reads land on freshly modified data, including back-to-back
    // read-after-write on the same word. Bases near the top push relative runtime
    // references over the end of the bank.
    task automatic random_access();
        int               pick;
        logic [1:0]       op_mode;
        logic [WORD_W-1:0] word;
        logic [SHIFT_W-1:0] shift;
        logic [BASE_W-1:0] base;
        logic [DATA_W-1:0] wdata;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            op_mode = MODE_READ;
        end
        else if (pick < 70)
        begin
            op_mode = MODE_WRITE;
        end
        else if (pick < 95)
        begin
            op_mode = MODE_NARROW;
        end
        else
        begin
            op_mode = MODE_IDLE;
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            word = WORD_W'($urandom_range(0, 3));
        end
        else if (pick < 70)
        begin
            word = WORD_W'($urandom_range(124, 127));
        end
        else
        begin
            word = WORD_W'($urandom_range(0, 127));
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            shift = '0;
        end
        else if (pick < 50)
        begin
            shift = SHIFT_W'($urandom_range(24, 31));
        end
        else
        begin
            shift = SHIFT_W'($urandom_range(0, 31));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            base = BASE_W'($urandom_range(0, 3));
        end
        else if (pick < 70)
        begin
            base = BASE_W'($urandom_range(380, 511));
        end
        else
        begin
            base = BASE_W'($urandom_range(0, 511));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            wdata = '1;
        end
        else if (pick < 15)
        begin
            wdata = '0;
        end
        else
        begin
            wdata = $urandom;
        end
        send_access(op_mode, make_ref(1'($urandom_range(0, 1)), KIND_W'($urandom_range(0, 7)),
                                      word, shift),
                    base, wdata);
    endtask

    // A random width per kind, weighted toward zero, exactly 32 and the values above
    // the documented range.
    function automatic logic [KIND_COUNT*WIDTH_W-1:0] random_widths();
        logic [KIND_COUNT*WIDTH_W-1:0] widths;
        int pick;
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                widths[k*WIDTH_W +: WIDTH_W] = 6'd0;
            end
            else if (pick < 35)
            begin
                widths[k*WIDTH_W +: WIDTH_W] = 6'd32;
            end
            else if (pick < 50)
            begin
                widths[k*WIDTH_W +: WIDTH_W] = WIDTH_W'($urandom_range(33, 63));
            end
            else
            begin
                widths[k*WIDTH_W +: WIDTH_W] = WIDTH_W'($urandom_range(1, 31));
            end
        end
        return widths;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked accesses at the reset widths of 32: cleared banks, full-word writes,
    // a field running past bit 31, narrow writes, relative references at and over the
    // top of the runtime bank, the relative bit on a game kind, and mode 3.
    task automatic test_directed();
        send_access(MODE_READ,   make_ref(1'b0, 3'd0, 7'd0,   5'd0),  9'd0,   '0);
        send_access(MODE_READ,   make_ref(1'b0, 3'd3, 7'd127, 5'd0),  9'd0,   '0);
        send_access(MODE_WRITE,  make_ref(1'b0, 3'd0, 7'd0,   5'd0),  9'd0,   32'hFFFF_FFFF);
        send_access(MODE_READ,   make_ref(1'b0, 3'd0, 7'd0,   5'd0),  9'd0,   '0);
        // Only bit 0 of the value survives a write at shift 31.
        send_access(MODE_WRITE,  make_ref(1'b0, 3'd1, 7'd0,   5'd31), 9'd0,   32'hFFFF_FFFE);
        send_access(MODE_READ,   make_ref(1'b0, 3'd1, 7'd0,   5'd30), 9'd0,   '0);
        send_access(MODE_READ,   make_ref(1'b0, 3'd2, 7'd0,   5'd0),  9'd0,   '0);
        // Narrow write at width 32 touches 31 bits.
        send_access(MODE_NARROW, make_ref(1'b0, 3'd0, 7'd1,   5'd0),  9'd0,   32'hFFFF_FFFF);
        send_access(MODE_READ,   make_ref(1'b0, 3'd0, 7'd1,   5'd0),  9'd0,   '0);
        // Last runtime word reached through a relative reference.
        send_access(MODE_WRITE,  make_ref(1'b1, 3'd7, 7'd127, 5'd0),  9'd384, 32'hA5A5_A5A5);
        send_access(MODE_READ,   make_ref(1'b1, 3'd4, 7'd100, 5'd4),  9'd411, '0);
        // One word past the runtime bank: flagged and ignored.
        send_access(MODE_WRITE,  make_ref(1'b1, 3'd5, 7'd127, 5'd0),  9'd385, 32'h1234_5678);
        send_access(MODE_READ,   make_ref(1'b1, 3'd5, 7'd127, 5'd0),  9'd385, '0);
        send_access(MODE_READ,   16'hFFFF,                            9'd511, '0);
        // The relative bit is ignored on a game kind.
        send_access(MODE_WRITE,  make_ref(1'b1, 3'd2, 7'd5,   5'd0),  9'd511, 32'h1234_5678);
        send_access(MODE_READ,   make_ref(1'b0, 3'd0, 7'd5,   5'd0),  9'd0,   '0);
        send_access(MODE_IDLE,   make_ref(1'b0, 3'd0, 7'd5,   5'd0),  9'd0,   32'hFFFF_FFFF);
        send_access(MODE_IDLE,   16'hFFFF,                            9'd511, 32'hFFFF_FFFF);
        send_access(MODE_WRITE,  make_ref(1'b0, 3'd0, 7'd0,   5'd0),  9'd0,   '0);
        send_access(MODE_READ,   make_ref(1'b0, 3'd0, 7'd0,   5'd0),  9'd0,   '0);
        send_access(MODE_READ,   make_ref(1'b1, 3'd6, 7'd0,   5'd0),  9'd0,   '0);
        send_access(MODE_READ,   make_ref(1'b1, 3'd7, 7'd127, 5'd0),  9'd384, '0);
        drain();
    endtask

    // Random traffic at the reset widths. This phase ends with the sender holding off
    // until every outstanding result has come back.
    task automatic test_random_reset_widths();
        repeat (300) random_access();
        drain();
    endtask

    // The width extremes: zero for every kind (writes and narrow writes change nothing,
    // reads return zero), one for every kind (a narrow write has an empty mask), and a mix
    // that includes the register values above 32 that still mean a full word.
    task automatic test_width_extremes();
        configure_widths({KIND_COUNT{6'd0}});
        repeat (150) random_access();
        drain();
        configure_widths({KIND_COUNT{6'd1}});
        repeat (150) random_access();
        drain();
        configure_widths({6'd63, 6'd33, 6'd32, 6'd31, 6'd16, 6'd8, 6'd2, 6'd63});
        repeat (150) random_access();
        drain();
    endtask

    // Several phases, each with a fresh random width per kind.
    task automatic test_random_widths();
        repeat (4)
        begin
            configure_widths(random_widths());
            repeat (250) random_access();
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    initial
    begin
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            kind_widths[k] = WIDTH_RESET;
        end
        for (int i = 0; i < GAME_WORDS; i++)
        begin
            game_bank[i] = '0;
        end
        for (int i = 0; i < RUNTIME_WORDS; i++)
        begin
            runtime_bank[i] = '0;
        end

        // Reset is released on a falling edge. The block then
        // clears its banks with in_stall high; the first transaction simply waits.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_reset_widths();
        test_width_extremes();
        test_random_widths();

        if (error_count == 0)
        begin
            $display("packed_variable_store_top_tb: done, clean");
        end
        else
        begin
            $display("packed_variable_store_top_tb: done, errors");
        end
        $finish;
    end

endmodule
